@@ src/cbps_pkg.sv @@
package cbps_pkg;

  // Default number of curve samples for each window of four control points.
  localparam int SAMPLES_DEFAULT = 20;

  // Coordinate format: ports are fixed at 32 bits, results saturate to SAT_W bits.
  localparam int COORD_WIDTH = 32;
  localparam int COORD_W     = 32;
  localparam int SAT_W       = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  // Bernstein weights are unsigned Q1.16, so 1.0 needs seventeen bits.
  localparam int WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  // Datapath widths: product of a coordinate with a weight, sum of four, rounded value.
  localparam int PROD_W  = COORD_W + WEIGHT_W + 1;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ROUND_W = SUM_W - 16;

  // Saturation limits in the rounded domain.
  localparam logic signed [ROUND_W-1:0] SAT_MAX =
    ROUND_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [ROUND_W-1:0] SAT_MIN = -SAT_MAX - ROUND_W'(1);

  // Job kinds handed from the front to the back.
  localparam logic [1:0] KIND_NONE  = 2'd0;  // nothing to emit
  localparam logic [1:0] KIND_ONE   = 2'd1;  // emit the current point
  localparam logic [1:0] KIND_TWO   = 2'd2;  // emit the held point, then the current one
  localparam logic [1:0] KIND_CURVE = 2'd3;  // emit the curve samples, then maybe the point

  typedef logic signed [COORD_W-1:0] coord_t;

  // One job: control points with index 3 the current point, index 2 the newest kept one.
  typedef struct packed {
    logic [1:0]       kind;
    logic             path_end;
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;
  } job_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } result_t;

  // Clamp a rounded value to the coordinate range and bring it to port width.
  function automatic logic [COORD_W-1:0] saturate(input logic signed [ROUND_W-1:0] v);
    logic signed [ROUND_W-1:0] c;
    begin
      if (v > SAT_MAX) begin
        c = SAT_MAX;
      end else if (v < SAT_MIN) begin
        c = SAT_MIN;
      end else begin
        c = v;
      end
      saturate = c[COORD_W-1:0];
    end
  endfunction

endpackage

@@ src/cbps_front.sv @@
module cbps_front import cbps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic               end_of_path,
  input  logic               queue_full,
  output logic               job_push,
  output job_t               job
);

  logic [COORD_W-1:0] win_x [3];
  logic [COORD_W-1:0] win_y [3];
  logic [1:0]         points_seen;
  logic               accept;
  logic [1:0]         kind;

  assign accept = push && !queue_full;

  // Classify the incoming point by its place in the path.
  always_comb begin
    case (points_seen)
      2'd0: kind = KIND_ONE;
      2'd1: kind = end_of_path ? KIND_ONE : KIND_NONE;
      2'd2: kind = end_of_path ? KIND_TWO : KIND_NONE;
      default: kind = KIND_CURVE;
    endcase
  end

  // Build the job from the kept window and the current point.
  always_comb begin
    job.kind     = kind;
    job.path_end = end_of_path;
    job.px       = {point_x, win_x[2], win_x[1], win_x[0]};
    job.py       = {point_y, win_y[2], win_y[1], win_y[0]};
  end

  assign job_push = accept && (kind != KIND_NONE);

  // Shift the window and count points on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        win_x[i] <= '0;
        win_y[i] <= '0;
      end
    end else if (accept) begin
      win_x[0] <= win_x[1];
      win_y[0] <= win_y[1];
      win_x[1] <= win_x[2];
      win_y[1] <= win_y[2];
      win_x[2] <= point_x;
      win_y[2] <= point_y;
      if (end_of_path) begin
        points_seen <= 2'd0;
      end else if (points_seen != 2'd3) begin
        points_seen <= points_seen + 2'd1;
      end
    end
  end

endmodule

@@ src/cbps_job_queue.sv @@
module cbps_job_queue import cbps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic valid
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign rd_job = slot[rd_ptr];

  // Job storage: payload needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/cbps_back.sv @@
module cbps_back import cbps_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               path_done
);

  localparam int STEP_W     = $clog2(SAMPLES + 1);
  localparam int K_W        = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = 2;
  localparam int OUT_CNT_W  = 3;
  localparam longint unsigned N  = longint'(SAMPLES);
  localparam longint unsigned N3 = N * N * N;
  localparam logic [STEP_W-1:0] STEP_LAST_SAMPLE = STEP_W'(SAMPLES - 1);
  localparam logic [STEP_W-1:0] STEP_FINAL_POINT = STEP_W'(SAMPLES);

  // Bernstein weight table, one row of four weights for each sample.
  logic [WEIGHT_W-1:0] w_tab [SAMPLES][4];

  for (genvar k = 0; k < SAMPLES; k++) begin : g_weight
    localparam longint unsigned U  = N - longint'(k);
    localparam longint unsigned K  = longint'(k);
    localparam longint unsigned W0 = (65536 * U * U * U * 2 + N3) / (2 * N3);
    localparam longint unsigned W1 = (65536 * 3 * U * U * K * 2 + N3) / (2 * N3);
    localparam longint unsigned W2 = (65536 * 3 * U * K * K * 2 + N3) / (2 * N3);
    localparam longint unsigned W3 = (65536 * K * K * K * 2 + N3) / (2 * N3);
    assign w_tab[k][0] = WEIGHT_W'(W0);
    assign w_tab[k][1] = WEIGHT_W'(W1);
    assign w_tab[k][2] = WEIGHT_W'(W2);
    assign w_tab[k][3] = WEIGHT_W'(W3);
  end

  logic [STEP_W-1:0]    step;
  logic [STEP_W-1:0]    last_step;
  logic [WEIGHT_W-1:0]  w_sel [4];
  logic                 op_done;
  logic                 credit_ok;
  logic                 issue;

  logic                     s1_valid;
  logic                     s1_done;
  logic signed [PROD_W-1:0] prod_x [4];
  logic signed [PROD_W-1:0] prod_y [4];

  logic                    s2_valid;
  logic                    s2_done;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;

  result_t                ofifo [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic [OUT_CNT_W-1:0]   count;
  logic [OUT_CNT_W-1:0]   pending;
  logic                   out_pop;
  result_t                wr_res;

  // Choose the weights for the current step of the job at the head of the queue.
  // A passed-through point is a blend with a single weight of one.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      w_sel[j] = '0;
    end
    op_done   = 1'b0;
    last_step = '0;
    case (job.kind)
      KIND_CURVE: begin
        last_step = job.path_end ? STEP_FINAL_POINT : STEP_LAST_SAMPLE;
        if (step < STEP_FINAL_POINT) begin
          for (int j = 0; j < 4; j++) begin
            w_sel[j] = w_tab[step[K_W-1:0]][j];
          end
        end else begin
          w_sel[3] = WEIGHT_ONE;
          op_done  = 1'b1;
        end
      end
      KIND_TWO: begin
        last_step = STEP_W'(1);
        if (step == '0) begin
          w_sel[2] = WEIGHT_ONE;
        end else begin
          w_sel[3] = WEIGHT_ONE;
          op_done  = 1'b1;
        end
      end
      default: begin
        w_sel[3] = WEIGHT_ONE;
        op_done  = job.path_end;
      end
    endcase
  end

  // Issue only when the output queue is sure to have room for the result.
  assign pending   = count + OUT_CNT_W'(s1_valid) + OUT_CNT_W'(s2_valid);
  assign credit_ok = (pending < OUT_CNT_W'(OUT_DEPTH));
  assign issue     = job_valid && credit_ok;
  assign job_pop   = issue && (step == last_step);

  // Step counter within the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (issue) begin
      if (step == last_step) begin
        step <= '0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Stage one: eight weight products.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      prod_x[j] <= $signed(job.px[j]) * $signed({1'b0, w_sel[j]});
      prod_y[j] <= $signed(job.py[j]) * $signed({1'b0, w_sel[j]});
    end
    s1_done <= op_done;
  end

  // Stage two: sum of four products plus the rounding half.
  always_ff @(posedge clk) begin
    sum_x <= SUM_W'(prod_x[0]) + SUM_W'(prod_x[1]) + SUM_W'(prod_x[2])
           + SUM_W'(prod_x[3]) + SUM_W'(32768);
    sum_y <= SUM_W'(prod_y[0]) + SUM_W'(prod_y[1]) + SUM_W'(prod_y[2])
           + SUM_W'(prod_y[3]) + SUM_W'(32768);
    s2_done <= s1_done;
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Stage three: drop the fraction, saturate and queue the result.
  always_comb begin
    wr_res.x    = saturate(sum_x[SUM_W-1:16]);
    wr_res.y    = saturate(sum_y[SUM_W-1:16]);
    wr_res.done = s2_done;
  end

  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      ofifo[wr_ptr] <= wr_res;
    end
  end

  // Output queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      case ({s2_valid, out_pop})
        2'b10:   count <= count + OUT_CNT_W'(1);
        2'b01:   count <= count - OUT_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign empty     = (count == '0);
  assign out_x     = ofifo[rd_ptr].x;
  assign out_y     = ofifo[rd_ptr].y;
  assign path_done = ofifo[rd_ptr].done;

endmodule

@@ src/cubic_bezier_path_smoother.sv @@
// Cubic Bezier path smoother. Path points (Q16.16 x and y) are pushed one per request with
// end_of_path on the final one; results are popped from a queue-style port. The first point
// of a path is passed straight through, and every point from the fourth on closes a window of
// four control points from which SAMPLES curve points are produced at t = k/SAMPLES,
// k = 0 .. SAMPLES-1; the final point of such a path follows the samples with path_done set.
// Paths of up to three points come out unchanged. The blend unit produces one result per cycle
// while the output queue has room for it, and a two-entry job queue lets the front take the
// next points meanwhile. A result passes through the job queue, the product and sum stages
// and the output queue. Results are rounded to nearest and saturated.
module cubic_bezier_path_smoother import cbps_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] point_x,
  input  logic [COORD_W-1:0] point_y,
  input  logic               end_of_path,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic               path_done
);

  logic job_push;
  job_t job_in;
  logic job_pop;
  job_t job_head;
  logic job_valid;

  // Front: window and classification.
  cbps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .point_x     (point_x),
    .point_y     (point_y),
    .end_of_path (end_of_path),
    .queue_full  (full),
    .job_push    (job_push),
    .job         (job_in)
  );

  // Short queue between front and back.
  cbps_job_queue u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .full   (full),
    .rd_en  (job_pop),
    .rd_job (job_head),
    .valid  (job_valid)
  );

  // Back: blend pipeline and result queue.
  cbps_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_x     (out_x),
    .out_y     (out_y),
    .path_done (path_done)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import cbps_pkg::*;

  localparam int SAMPLES    = SAMPLES_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 20;

  localparam coord_t C_MAX  = 32'sh7fffffff;
  localparam coord_t C_MIN  = 32'sh80000000;
  localparam coord_t C_ZERO = 32'sh00000000;
  localparam coord_t C_NEG1 = 32'shffffffff;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   done;
  } smooth_pt_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [COORD_W-1:0] point_x = '0;
  logic [COORD_W-1:0] point_y = '0;
  logic               end_of_path = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic               path_done;

  // Expected smoothed points, oldest first, and the predictor's copy of the path window.
  smooth_pt_t pending_pts[$];
  coord_t     win_x[3];
  coord_t     win_y[3];
  int         path_len = 0;

  int         fails = 0;
  int         sender_gap = 0;
  int         pop_hold = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  int         points_sent = 0;

  cubic_bezier_path_smoother dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .point_x    (point_x),
    .point_y    (point_y),
    .end_of_path(end_of_path),
    .empty      (empty),
    .pop        (pop),
    .out_x      (out_x),
    .out_y      (out_y),
    .path_done  (path_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none, some short, a few long; none at all in a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Bernstein weight in Q1.16: c * (n-k)^ua * k^kb / n^3, rounded half up.
  function automatic longint bern_weight(input longint c, input int ua, input int kb,
                                         input int k);
    longint num;
    longint n3;
    num = c * 65536;
    n3  = longint'(SAMPLES) * SAMPLES * SAMPLES;
    repeat (ua) num = num * (SAMPLES - k);
    repeat (kb) num = num * k;
    return (2 * num + n3) / (2 * n3);
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (SAT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // Weighted sum of four control coordinates, rounded to nearest with halves upwards.
  function automatic coord_t blend_coord(input coord_t p0, input coord_t p1,
                                         input coord_t p2, input coord_t p3,
                                         input longint w[4]);
    longint acc;
    acc = longint'(p0) * w[0] + longint'(p1) * w[1] + longint'(p2) * w[2]
        + longint'(p3) * w[3];
    return clamp_coord((acc + 64'sd32768) >>> 16);
  endfunction

  function automatic void expect_pt(input coord_t x, input coord_t y, input logic done);
    smooth_pt_t pt;
    pt.x    = clamp_coord(longint'(x));
    pt.y    = clamp_coord(longint'(y));
    pt.done = done;
    pending_pts.insert(pending_pts.size(), pt);
  endfunction

  // Works out the smoothed points that one accepted path point causes.
  function automatic void smooth_point(input coord_t x, input coord_t y, input logic eop);
    longint w[4];
    case (path_len)
      0: expect_pt(x, y, eop);
      1: begin
        if (eop) expect_pt(x, y, 1'b1);
      end
      2: begin
        if (eop) begin
          expect_pt(win_x[2], win_y[2], 1'b0);
          expect_pt(x, y, 1'b1);
        end
      end
      default: begin
        for (int k = 0; k < SAMPLES; k++) begin
          w[0] = bern_weight(1, 3, 0, k);
          w[1] = bern_weight(3, 2, 1, k);
          w[2] = bern_weight(3, 1, 2, k);
          w[3] = bern_weight(1, 0, 3, k);
          expect_pt(blend_coord(win_x[0], win_x[1], win_x[2], x, w),
                    blend_coord(win_y[0], win_y[1], win_y[2], y, w), 1'b0);
        end
        if (eop) expect_pt(x, y, 1'b1);
      end
    endcase
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = win_x[2];
    win_y[1] = win_y[2];
    win_x[2] = x;
    win_y[2] = y;
    path_len = eop ? 0 : ((path_len >= 3) ? 3 : path_len + 1);
  endfunction

  // Sends one path point and waits for its request to be taken. Push stays high into the
  // next point when no gap follows, so it is never lowered and raised in one step.
  task automatic send_point(input coord_t x, input coord_t y, input logic eop);
    repeat (sender_gap) @(posedge clk);
    push        <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    end_of_path <= eop;
    @(posedge clk);
    while (full) @(posedge clk);
    smooth_point(x, y, eop);
    points_sent++;
    sender_gap = pick_gap();
    if (sender_gap > 0) push <= 1'b0;
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return coord_t'($urandom);
    if (r < 8) return coord_t'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
    if (r == 8) return $urandom_range(0, 1) ? C_MAX : C_MIN;
    return $urandom_range(0, 1) ? C_MAX - coord_t'($urandom_range(0, 65536))
                                : C_MIN + coord_t'($urandom_range(0, 65536));
  endfunction

  // One-point paths at the corners of the coordinate range and next to zero.
  task automatic test_single_points();
    send_point(C_MAX, C_MIN, 1'b1);
    send_point(C_MIN, C_MAX, 1'b1);
    send_point(C_ZERO, C_NEG1, 1'b1);
    send_point(C_NEG1, C_ZERO, 1'b1);
  endtask

  // Two- and three-point paths; the second point of a three-point path is held and comes out only at the end.
  task automatic test_short_paths();
    send_point(32'sh00010000, 32'sh00020000, 1'b0);
    send_point(C_MAX, C_MIN, 1'b1);
    send_point(32'sh55555555, 32'shaaaaaaaa, 1'b0);
    send_point(32'shaaaaaaaa, 32'sh55555555, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);
  endtask

  // Full windows at the extremes, where rounded weights can push the sum past the range.
  task automatic test_extreme_curves();
    repeat (3) send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MAX, C_MAX, 1'b1);
    repeat (3) send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MIN, C_MIN, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(32'sh55555555, 32'shaaaaaaaa, 1'b0);
    send_point(32'shaaaaaaaa, 32'sh55555555, 1'b1);
  endtask

  // Random paths, mostly long enough to reach the curve windows, a few of one to three points.
  task automatic test_random_paths(input int target);
    int len;
    while (points_sent < target) begin
      calm = ($urandom_range(0, 7) == 0);
      len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      for (int i = 0; i < len; i++) begin
        send_point(rand_coord(), rand_coord(), i == len - 1);
      end
    end
    calm = 1'b0;
  endtask

  // Result side: pop with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop_hold = pick_gap();
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each popped result with the oldest expected point.
  always @(posedge clk) begin
    smooth_pt_t want;
    if (!rst && pop && !empty) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result: out_x %0d out_y %0d path_done %0b",
               $signed(out_x), $signed(out_y), path_done);
        fails++;
      end else begin
        want = pending_pts.pop_front();
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, $signed(out_x));
          fails++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, $signed(out_y));
          fails++;
        end
        if (path_done !== want.done) begin
          $error("path_done: expected %0b, got %0b", want.done, path_done);
          fails++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[cubic_bezier_path_smoother] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_points();
    test_short_paths();
    test_extreme_curves();
    test_random_paths(500);

    if (sender_gap == 0) push <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fails == 0) begin
      $display("[cubic_bezier_path_smoother] OK");
    end else begin
      $display("[cubic_bezier_path_smoother] ERROR");
    end
    $finish;
  end

endmodule
